// File: sv/b2r_pkg.sv
// Shared constants and lookup functions for the binary to Roman numeral converter.
package b2r_pkg;

	localparam int unsigned VALUE_W  = 12;
	localparam int unsigned SYMBOL_W = 7;
	localparam int unsigned IDX_W    = 4;

	localparam logic [VALUE_W-1:0] MAX_VALUE = 12'd3999;
	localparam logic [IDX_W-1:0]   LAST_IDX  = 4'd12;

	localparam logic [SYMBOL_W-1:0] CH_NONE = 7'h00;
	localparam logic [SYMBOL_W-1:0] CH_M    = 7'h4D;
	localparam logic [SYMBOL_W-1:0] CH_D    = 7'h44;
	localparam logic [SYMBOL_W-1:0] CH_C    = 7'h43;
	localparam logic [SYMBOL_W-1:0] CH_L    = 7'h4C;
	localparam logic [SYMBOL_W-1:0] CH_X    = 7'h58;
	localparam logic [SYMBOL_W-1:0] CH_V    = 7'h56;
	localparam logic [SYMBOL_W-1:0] CH_I    = 7'h49;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_CONV  = 3'b010,
		ST_FAULT = 3'b100
	} state_t;

	// Weight of each entry of the greedy table, largest first.
	function automatic logic [VALUE_W-1:0] entry_weight(input logic [IDX_W-1:0] idx);
		logic [VALUE_W-1:0] w;
		case (idx)
			4'd0:    w = 12'd1000;
			4'd1:    w = 12'd900;
			4'd2:    w = 12'd500;
			4'd3:    w = 12'd400;
			4'd4:    w = 12'd100;
			4'd5:    w = 12'd90;
			4'd6:    w = 12'd50;
			4'd7:    w = 12'd40;
			4'd8:    w = 12'd10;
			4'd9:    w = 12'd9;
			4'd10:   w = 12'd5;
			4'd11:   w = 12'd4;
			4'd12:   w = 12'd1;
			default: w = 12'd1;
		endcase
		return w;
	endfunction

	// Odd entries are the subtractive forms, which take two letters.
	function automatic logic entry_pair(input logic [IDX_W-1:0] idx);
		return idx[0] && (idx <= LAST_IDX);
	endfunction

	// Leading letter of a subtractive form.
	function automatic logic [SYMBOL_W-1:0] entry_lead(input logic [IDX_W-1:0] idx);
		logic [SYMBOL_W-1:0] c;
		case (idx)
			4'd1, 4'd3: c = CH_C;
			4'd5, 4'd7: c = CH_X;
			default:    c = CH_I;
		endcase
		return c;
	endfunction

	// Letter that completes an entry: the only letter of a plain entry.
	function automatic logic [SYMBOL_W-1:0] entry_tail(input logic [IDX_W-1:0] idx);
		logic [SYMBOL_W-1:0] c;
		case (idx)
			4'd0, 4'd1: c = CH_M;
			4'd2, 4'd3: c = CH_D;
			4'd4, 4'd5: c = CH_C;
			4'd6, 4'd7: c = CH_L;
			4'd8, 4'd9: c = CH_X;
			4'd10, 4'd11: c = CH_V;
			default:    c = CH_I;
		endcase
		return c;
	endfunction

endpackage

// File: sv/binary_to_roman_numeral_core.sv
// Binary to Roman numeral converter: greedy table walk over one shared subtractor.
// Once an item is accepted, the sequencer steps past every table entry whose weight is
// above the remainder and sends each letter through the output register; it takes no new
// item until its last letter has gone in, as every step uses the single compare and
// subtract unit. An out-of-range item gives one blank error result, and a stalled output
// holds back the letters. Reset (arst_n, asynchronous) idles the sequencer.
module binary_to_roman_numeral_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [b2r_pkg::VALUE_W-1:0]        value,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [b2r_pkg::SYMBOL_W-1:0]       symbol,
	output logic                               last,
	output logic                               out_of_range
);

	b2r_pkg::state_t state_q;

	// Remainder still to be written as letters, and the current table entry.
	logic [b2r_pkg::VALUE_W-1:0] rem_q;
	logic [b2r_pkg::IDX_W-1:0]   idx_q;
	// Set once the leading letter of a subtractive form has gone out.
	logic                        half_q;

	logic                         out_valid_q;
	logic [b2r_pkg::SYMBOL_W-1:0] symbol_q;
	logic                         last_q;
	logic                         oor_q;

	logic                         in_accept;
	logic                         value_bad;
	logic                         slot_free;
	logic [b2r_pkg::VALUE_W-1:0]  weight;
	logic [b2r_pkg::VALUE_W:0]    diff;
	logic                         fits;
	logic                         pair;
	logic                         lead_step;
	logic                         rem_zero;
	logic                         emit;
	logic [b2r_pkg::SYMBOL_W-1:0] emit_symbol;
	logic                         emit_last;
	logic                         emit_oor;

	// The block takes a new item only when the sequencer is idle.
	assign in_stall  = (state_q != b2r_pkg::ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign value_bad = (value == '0) || (value > b2r_pkg::MAX_VALUE);

	// The output register can take a new item when it is empty or being drained.
	assign slot_free = !out_valid_q || !out_stall;

	// The shared unit: one subtraction whose borrow doubles as the compare.
	assign weight = b2r_pkg::entry_weight(idx_q);
	assign diff   = {1'b0, rem_q} - {1'b0, weight};
	assign fits   = !diff[b2r_pkg::VALUE_W];
	assign pair   = b2r_pkg::entry_pair(idx_q);

	// The first letter of a subtractive form leaves the remainder alone; the
	// second one, or the sole letter of a plain entry, takes the weight off.
	assign lead_step = pair && !half_q;
	assign rem_zero  = (diff[b2r_pkg::VALUE_W-1:0] == '0);

	always_comb begin
		emit        = 1'b0;
		emit_symbol = b2r_pkg::CH_NONE;
		emit_last   = 1'b0;
		emit_oor    = 1'b0;
		unique case (state_q)
			b2r_pkg::ST_CONV: begin
				if (fits && slot_free) begin
					emit = 1'b1;
					if (lead_step) begin
						emit_symbol = b2r_pkg::entry_lead(idx_q);
					end else begin
						emit_symbol = b2r_pkg::entry_tail(idx_q);
						emit_last   = rem_zero;
					end
				end
			end
			b2r_pkg::ST_FAULT: begin
				if (slot_free) begin
					emit      = 1'b1;
					emit_last = 1'b1;
					emit_oor  = 1'b1;
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= b2r_pkg::ST_IDLE;
			half_q  <= 1'b0;
		end else begin
			unique case (state_q)
				b2r_pkg::ST_IDLE: begin
					half_q <= 1'b0;
					if (in_accept) begin
						state_q <= value_bad ? b2r_pkg::ST_FAULT : b2r_pkg::ST_CONV;
					end
				end
				b2r_pkg::ST_CONV: begin
					if (emit) begin
						half_q <= lead_step;
						if (emit_last) begin
							state_q <= b2r_pkg::ST_IDLE;
						end
					end
				end
				b2r_pkg::ST_FAULT: begin
					if (emit) begin
						state_q <= b2r_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= b2r_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Remainder and table position; these need no reset as they are loaded
	// whenever an item is accepted.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			rem_q <= value;
			idx_q <= '0;
		end else if (state_q == b2r_pkg::ST_CONV) begin
			if (!fits) begin
				idx_q <= idx_q + 1'b1;
			end else if (emit && !lead_step) begin
				rem_q <= diff[b2r_pkg::VALUE_W-1:0];
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free) begin
			symbol_q <= emit_symbol;
			last_q   <= emit_last;
			oor_q    <= emit_oor;
		end
	end

	assign out_valid    = out_valid_q;
	assign symbol       = symbol_q;
	assign last         = last_q;
	assign out_of_range = oor_q;

`ifndef SYNTHESIS
	// An error result is always a lone, blank, final item.
	a_oor_form: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_of_range) |-> (last && (symbol == b2r_pkg::CH_NONE)))
		else $error("out-of-range item is not a blank final item");

	// While converting, something is always left to write and it is in range.
	a_rem_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == b2r_pkg::ST_CONV) |-> ((rem_q != '0) && (rem_q <= b2r_pkg::MAX_VALUE)))
		else $error("remainder left its legal range during conversion");

	// The table walk never runs past its final entry.
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == b2r_pkg::ST_CONV) |-> (idx_q <= b2r_pkg::LAST_IDX))
		else $error("table index ran past the last entry");

	// A bad value sends the sequencer to the error state.
	a_bad_fault: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && value_bad) |=> (state_q == b2r_pkg::ST_FAULT))
		else $error("bad value did not raise an error result");
`endif

endmodule

// File: verif/tb_binary_to_roman_numeral_core.sv
// Self-checking testbench for the binary to Roman numeral converter.
module tb_binary_to_roman_numeral_core;

	// The longest numeral (3888) has fifteen letters. The expected spelling of a number
	// is kept as a right-justified string of up to fifteen ASCII bytes. An all-zero word
	// stands for the single error result that a number out of range gives.
	localparam int MAX_LETTERS  = 15;
	localparam int WORD_W       = 8 * MAX_LETTERS;
	localparam int DIR_N        = 25;
	localparam int RANDOM_N     = 395;
	localparam int HOLD_AFTER   = DIR_N + 40;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 400000;

	typedef enum logic {
		ROW_TYPED,
		ROW_PREDICTED
	} row_kind_t;

	typedef struct packed {
		row_kind_t                   kind;
		logic [b2r_pkg::VALUE_W-1:0] number;
		logic [WORD_W-1:0]           spelled;
	} stim_row_t;

	typedef struct {
		logic [b2r_pkg::SYMBOL_W-1:0] symbol;
		logic                         last;
		logic                         out_of_range;
		logic [b2r_pkg::VALUE_W-1:0]  number;
		int                           index;
	} letter_t;

	logic                         clk          = 1'b0;
	logic                         arst_n       = 1'b0;
	logic                         in_valid     = 1'b0;
	logic                         in_stall;
	logic [b2r_pkg::VALUE_W-1:0]  value        = '0;
	logic                         out_valid;
	logic                         out_stall    = 1'b0;
	logic [b2r_pkg::SYMBOL_W-1:0] symbol;
	logic                         last;
	logic                         out_of_range;

	letter_t pending_letters[$];

	int numbers_sent   = 0;
	int rejects_sent   = 0;
	int letters_seen   = 0;
	int mismatches     = 0;
	int stalled_offers = 0;
	int cycle_count    = 0;
	int burst_left     = 0;

	// Directed items. Where the numeral can be read off at a glance it is typed in;
	// an empty spelling means the error result is expected. The other rows are
	// worked out by the predictor. The rows cover both ends of the valid range, the
	// error values on either side of it, every subtractive form, the longest numeral
	// and alternating bit patterns on the value field.
	stim_row_t directed_rows [DIR_N] = '{
		'{ROW_TYPED,     12'd1,    "I"},
		'{ROW_TYPED,     12'd3999, "MMMCMXCIX"},
		'{ROW_TYPED,     12'd0,    ""},
		'{ROW_TYPED,     12'd4000, ""},
		'{ROW_TYPED,     12'd4095, ""},
		'{ROW_PREDICTED, 12'd3888, ""},
		'{ROW_TYPED,     12'd4,    "IV"},
		'{ROW_TYPED,     12'd9,    "IX"},
		'{ROW_TYPED,     12'd5,    "V"},
		'{ROW_TYPED,     12'd40,   "XL"},
		'{ROW_TYPED,     12'd90,   "XC"},
		'{ROW_TYPED,     12'd400,  "CD"},
		'{ROW_TYPED,     12'd900,  "CM"},
		'{ROW_TYPED,     12'd1000, "M"},
		'{ROW_TYPED,     12'd3000, "MMM"},
		'{ROW_TYPED,     12'd2,    "II"},
		'{ROW_PREDICTED, 12'd2048, ""},
		'{ROW_PREDICTED, 12'd1994, ""},
		'{ROW_PREDICTED, 12'd444,  ""},
		'{ROW_PREDICTED, 12'd2730, ""},
		'{ROW_PREDICTED, 12'd1365, ""},
		'{ROW_PREDICTED, 12'd3,    ""},
		'{ROW_PREDICTED, 12'd8,    ""},
		'{ROW_PREDICTED, 12'd50,   ""},
		'{ROW_PREDICTED, 12'd500,  ""}
	};

	binary_to_roman_numeral_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.value        (value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.symbol       (symbol),
		.last         (last),
		.out_of_range (out_of_range)
	);

	always #4 clk = ~clk;

	// Shifts one more letter in at the bottom of a spelling.
	function automatic logic [WORD_W-1:0] add_letter(input logic [WORD_W-1:0] word,
			input logic [b2r_pkg::SYMBOL_W-1:0] ch);
		return {word[WORD_W-9:0], 1'b0, ch};
	endfunction

	// Spells a number as a Roman numeral. Thousands become a run of M; each lower
	// digit uses its place's one, five and ten letters with the subtractive forms
	// for four and nine. Zero and anything above the valid range give an empty word.
	function automatic logic [WORD_W-1:0] spell_roman(input logic [b2r_pkg::VALUE_W-1:0] v);
		logic [WORD_W-1:0]            word;
		logic [b2r_pkg::SYMBOL_W-1:0] one;
		logic [b2r_pkg::SYMBOL_W-1:0] five;
		logic [b2r_pkg::SYMBOL_W-1:0] ten;
		int unsigned                  rest;
		int unsigned                  digit;
		int unsigned                  scale;
		word = '0;
		if (v == '0 || v > b2r_pkg::MAX_VALUE)
			return word;
		rest = 32'(v);
		repeat (rest / 1000)
			word = add_letter(word, b2r_pkg::CH_M);
		rest  = rest % 1000;
		scale = 100;
		for (int place = 0; place < 3; place++) begin
			case (place)
				0: begin
					one = b2r_pkg::CH_C; five = b2r_pkg::CH_D; ten = b2r_pkg::CH_M;
				end
				1: begin
					one = b2r_pkg::CH_X; five = b2r_pkg::CH_L; ten = b2r_pkg::CH_C;
				end
				default: begin
					one = b2r_pkg::CH_I; five = b2r_pkg::CH_V; ten = b2r_pkg::CH_X;
				end
			endcase
			digit = rest / scale;
			rest  = rest % scale;
			scale = scale / 10;
			if (digit == 9) begin
				word = add_letter(add_letter(word, one), ten);
			end else if (digit == 4) begin
				word = add_letter(add_letter(word, one), five);
			end else begin
				if (digit >= 5)
					word = add_letter(word, five);
				repeat (digit % 5)
					word = add_letter(word, one);
			end
		end
		return word;
	endfunction

	// Offers one number and, once it has been taken, queues the letters it must give.
	// The sender works in bursts: at the end of each burst it may drop valid for a
	// random gap. A gap of zero leaves valid high, so that valid is never lowered and
	// raised again within one step. Now and then a burst is long enough to keep the
	// input busy for a good stretch.
	task automatic offer_number(input row_kind_t kind, input logic [b2r_pkg::VALUE_W-1:0] v,
			input logic [WORD_W-1:0] typed);
		logic [WORD_W-1:0] word;
		letter_t           entry;
		int                gap;
		int                n;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
			                                         : $urandom_range(1, 10);
		end
		burst_left--;
		in_valid <= 1'b1;
		value    <= v;
		// Handshake signals are sampled as they stood just before the edge.
		do
			@(posedge clk);
		while (in_stall);
		numbers_sent++;
		word = (kind == ROW_PREDICTED) ? spell_roman(v) : typed;
		if (word == '0) begin
			entry.symbol       = b2r_pkg::CH_NONE;
			entry.last         = 1'b1;
			entry.out_of_range = 1'b1;
			entry.number       = v;
			entry.index        = 0;
			pending_letters.push_back(entry);
			rejects_sent++;
		end else begin
			n = 0;
			for (int b = MAX_LETTERS - 1; b >= 0; b--) begin
				if (word[8*b +: 8] != 8'h00) begin
					entry.symbol       = word[8*b +: b2r_pkg::SYMBOL_W];
					entry.last         = (b == 0);
					entry.out_of_range = 1'b0;
					entry.number       = v;
					entry.index        = n;
					pending_letters.push_back(entry);
					n++;
				end
			end
		end
	endtask

	// Receiver. It runs in segments of random length: free-flowing, stalling at random,
	// or toggling its stall every cycle. Once the random part is under way it holds off
	// for one long stretch while the sender keeps offering, so that the converter backs
	// up and has to stall its input.
	initial begin : receiver
		int  seg_kind;
		int  seg_len;
		bit  held;
		held = 1'b0;
		@(posedge clk);
		forever begin
			if (!held && numbers_sent >= HOLD_AFTER) begin
				held = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			seg_kind = $urandom_range(0, 2);
			seg_len  = $urandom_range(8, 60);
			repeat (seg_len) begin
				case (seg_kind)
					0:       out_stall <= 1'b0;
					1:       out_stall <= ($urandom_range(0, 2) == 0);
					default: out_stall <= ~out_stall;
				endcase
				@(posedge clk);
			end
		end
	end

	// Every letter that leaves the converter is matched against the oldest expectation.
	always @(posedge clk) begin : check_letters
		letter_t want;
		if (arst_n && out_valid && !out_stall) begin
			letters_seen++;
			if (pending_letters.size() == 0) begin
				if (mismatches < 10)
					$display("Unexpected letter: symbol %h last %b out_of_range %b",
					         symbol, last, out_of_range);
				mismatches++;
			end else begin
				want = pending_letters.pop_front();
				if (symbol !== want.symbol || last !== want.last ||
				    out_of_range !== want.out_of_range) begin
					if (mismatches < 10)
						$display({"Mismatch on letter %0d of %0d: expected symbol %h last %b ",
						          "out_of_range %b, got symbol %h last %b out_of_range %b"},
						         want.index, want.number, want.symbol, want.last,
						         want.out_of_range, symbol, last, out_of_range);
					mismatches++;
				end
			end
		end
	end

	// Cycles in which the converter refused an offered item.
	always @(posedge clk) begin
		if (in_valid && in_stall)
			stalled_offers++;
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timed out with %0d letters still expected.", pending_letters.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		logic [b2r_pkg::VALUE_W-1:0] v;
		int unsigned                 pick;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			offer_number(directed_rows[i].kind, directed_rows[i].number,
			             directed_rows[i].spelled);

		// Random numbers: mostly valid, a good share built from random digits so that
		// every digit pattern turns up in every place, some small ones and a few that
		// must be rejected.
		repeat (RANDOM_N) begin
			pick = $urandom_range(0, 99);
			if (pick < 8)
				v = ($urandom_range(0, 3) == 0) ? '0
				    : (b2r_pkg::VALUE_W)'($urandom_range(4000, 4095));
			else if (pick < 20)
				v = (b2r_pkg::VALUE_W)'($urandom_range(1, 99));
			else if (pick < 45)
				v = (b2r_pkg::VALUE_W)'(1000 * $urandom_range(0, 3) +
				                        100 * $urandom_range(0, 9) +
				                        10 * $urandom_range(0, 9) + $urandom_range(0, 9));
			else
				v = (b2r_pkg::VALUE_W)'($urandom_range(1, 3999));
			offer_number(ROW_PREDICTED, v, '0);
		end
		in_valid <= 1'b0;

		while (pending_letters.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Converted %0d numbers, %0d of them out of range, into %0d checked letters.",
		         numbers_sent, rejects_sent, letters_seen);
		$display("The input was held off on %0d cycles, including one long output hold-off.",
		         stalled_offers);
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches in total.", mismatches);
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
